[design/ascii_xy_packet_parser_unit_assert.svh]
// ----------------------------------------------------------------------------
// ascii_xy_packet_parser_unit_assert.svh - assertion macros
// Clocked assertion shorthands shared by the parser RTL.
// ----------------------------------------------------------------------------
`ifndef ASCII_XY_PACKET_PARSER_UNIT_ASSERT_SVH
`define ASCII_XY_PACKET_PARSER_UNIT_ASSERT_SVH

// Checked on every clk edge outside reset.
`define XYP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every clk edge, reset included.
`define XYP_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/xyp_pkg.sv]
// ----------------------------------------------------------------------------
// xyp_pkg - ASCII X/Y packet parser package
// Payload types, character codes, frame states and shared constants.
// ----------------------------------------------------------------------------
package xyp_pkg;

	localparam int FIELD_CHARS_DEF   = 10;
	localparam int FRACTION_BITS_DEF = 16;

	localparam int LEN_W   = 4;
	localparam int PLACE_W = 4;
	localparam int MAG_W   = 31;
	localparam int VAL_W   = 32;

	localparam logic [PLACE_W-1:0] PLACE_MAX = {PLACE_W{1'b1}};
	localparam logic [MAG_W-1:0]   MAG_MAX   = {MAG_W{1'b1}};

	localparam logic [7:0] CHAR_A     = 8'h41;
	localparam logic [7:0] CHAR_E     = 8'h45;
	localparam logic [7:0] CHAR_X     = 8'h58;
	localparam logic [7:0] CHAR_Y     = 8'h59;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_POINT = 8'h2E;
	localparam logic [7:0] CHAR_0     = 8'h30;
	localparam logic [7:0] CHAR_9     = 8'h39;

	localparam logic OP_BYTE    = 1'b0;
	localparam logic OP_TIMEOUT = 1'b1;

	localparam logic [63:0] POW_TEN [16] = '{
		64'd1, 64'd10, 64'd100, 64'd1000, 64'd10000, 64'd100000, 64'd1000000,
		64'd10000000, 64'd100000000, 64'd1000000000, 64'd10000000000,
		64'd100000000000, 64'd1000000000000, 64'd10000000000000,
		64'd100000000000000, 64'd1000000000000000
	};

	typedef struct packed {
		logic       op;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic                    x_update;
		logic signed [VAL_W-1:0] x_value;
		logic                    y_update;
		logic signed [VAL_W-1:0] y_value;
	} result_t;

	typedef enum logic [1:0] {
		FP_IDLE,
		FP_ONE_A,
		FP_IN_FRAME,
		FP_ONE_E
	} frame_state_t;

	// frame tracker -> top
	typedef struct packed {
		logic in_frame;
		logic trailer;
	} frm_t;

	// top -> field unit
	typedef struct packed {
		logic take;
		logic start;
		logic stop;
		logic trailer;
	} fld_ctl_t;

	// field unit -> top
	typedef struct packed {
		logic                    capturing;
		logic                    has_chars;
		logic signed [VAL_W-1:0] value;
	} fld_t;

endpackage

[design/xyp_frame.sv]
// ----------------------------------------------------------------------------
// xyp_frame - frame tracker
// Follows the AA header / EE trailer framing one byte per step.
// ----------------------------------------------------------------------------
module xyp_frame (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         step,
	input  logic [7:0]   ch,
	output xyp_pkg::frm_t frm
);
	import xyp_pkg::*;

	frame_state_t state_q;
	frame_state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FP_IDLE;
		end else if (step) begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx     = state_q;
		frm.in_frame = 1'b0;
		frm.trailer  = 1'b0;
		case (state_q)
			FP_IDLE: begin
				state_nx = (ch == CHAR_A) ? FP_ONE_A : FP_IDLE;
			end
			FP_ONE_A: begin
				// header mismatch drops back without rechecking this byte
				if (ch == CHAR_A) begin
					state_nx     = FP_IN_FRAME;
					frm.in_frame = 1'b1;
				end else begin
					state_nx = FP_IDLE;
				end
			end
			FP_IN_FRAME: begin
				if (ch == CHAR_E) begin
					state_nx = FP_ONE_E;
				end else begin
					frm.in_frame = 1'b1;
				end
			end
			FP_ONE_E: begin
				if (ch == CHAR_E) begin
					state_nx    = FP_IDLE;
					frm.trailer = 1'b1;
				end else begin
					state_nx     = FP_IN_FRAME;
					frm.in_frame = 1'b1;
				end
			end
			default: begin
				state_nx = FP_IDLE;
			end
		endcase
	end

endmodule

[design/xyp_field.sv]
// ----------------------------------------------------------------------------
// xyp_field - field capture unit
// Parses one signed decimal field into a saturating fixed-point magnitude.
// ----------------------------------------------------------------------------
module xyp_field #(
	parameter int FIELD_CHARS   = xyp_pkg::FIELD_CHARS_DEF,
	parameter int FRACTION_BITS = xyp_pkg::FRACTION_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       ch,
	input  xyp_pkg::fld_ctl_t ctl,
	output xyp_pkg::fld_t    st
);
	import xyp_pkg::*;

	localparam int IW = MAG_W + 5;

	logic               cap_q;
	logic [LEN_W-1:0]   len_q;
	logic               neg_q;
	logic               pt_q;
	logic [PLACE_W-1:0] place_q;
	logic [MAG_W-1:0]   mag_q;

	// rounded digit * 2^FRACTION_BITS / 10^k, indexed [digit][k]
	logic [MAG_W-1:0] frac_tab [16][16];

	for (genvar gd = 0; gd < 16; gd++) begin : g_d
		for (genvar gk = 0; gk < 16; gk++) begin : g_k
			localparam logic [63:0] P   = POW_TEN[gk];
			localparam logic [63:0] NUM = (64'(gd) << (FRACTION_BITS + 1)) + P;
			localparam logic [63:0] Q   = NUM / (2 * P);
			assign frac_tab[gd][gk] = Q[MAG_W-1:0];
		end
	end

	logic               full;
	logic               is_digit;
	logic [3:0]         digit;
	logic [PLACE_W-1:0] place_nx;
	logic [IW-1:0]      int_sum;
	logic [MAG_W:0]     frac_sum;
	logic [MAG_W-1:0]   int_sat;
	logic [MAG_W-1:0]   frac_sat;

	always_comb begin
		full     = (len_q >= LEN_W'(FIELD_CHARS));
		is_digit = ch inside {[CHAR_0:CHAR_9]};
		digit    = ch[3:0];
		place_nx = (place_q < PLACE_MAX) ? place_q + 1'b1 : PLACE_MAX;
		// m * 10 as shift-and-add
		int_sum  = ({5'b0, mag_q} << 3) + ({5'b0, mag_q} << 1)
			+ (IW'(digit) << FRACTION_BITS);
		frac_sum = {1'b0, mag_q} + {1'b0, frac_tab[digit][place_nx]};
		int_sat  = (int_sum > {5'b0, MAG_MAX}) ? MAG_MAX : int_sum[MAG_W-1:0];
		frac_sat = frac_sum[MAG_W] ? MAG_MAX : frac_sum[MAG_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= 1'b0;
			len_q   <= '0;
			neg_q   <= 1'b0;
			pt_q    <= 1'b0;
			place_q <= '0;
			mag_q   <= '0;
		end else if (ctl.take) begin
			if (ctl.start) begin
				cap_q   <= 1'b1;
				len_q   <= '0;
				neg_q   <= 1'b0;
				pt_q    <= 1'b0;
				place_q <= '0;
				mag_q   <= '0;
			end else begin
				// trailer closes capture before the byte is taken
				if (cap_q && !ctl.trailer && !full) begin
					if (len_q == '0 && ch == CHAR_MINUS) begin
						neg_q <= 1'b1;
					end else if (is_digit) begin
						mag_q <= pt_q ? frac_sat : int_sat;
						if (pt_q) begin
							place_q <= place_nx;
						end
					end
					if (ch == CHAR_POINT) begin
						pt_q    <= 1'b1;
						place_q <= '0;
					end
					len_q <= len_q + 1'b1;
				end
				if (ctl.stop || ctl.trailer) begin
					cap_q <= 1'b0;
				end
			end
		end
	end

	always_comb begin
		st.capturing = cap_q;
		st.has_chars = (len_q != '0);
		st.value     = neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
	end

endmodule

[design/ascii_xy_packet_parser_unit.sv]
// ----------------------------------------------------------------------------
// ascii_xy_packet_parser_unit - ASCII X/Y packet parser
// Takes one UART byte or a receive-timeout event per transfer and reports
// the X and Y deviations as signed fixed-point values. Frames open with
// "AA" and close with "EE"; inside a frame "X" or "Y" starts capture of a
// decimal field (optional leading minus, integer digits, point, fraction
// digits), parsed on the fly into a saturating magnitude with FRACTION_BITS
// fraction bits. At the trailer every field that holds characters is
// reported, stale ones included; a timeout reports both values as zero.
// Throughput is one transfer per cycle while no held result stalls: the
// input register feeds one pass of frame tracking and digit arithmetic
// (a shift-add times ten or a constant-table fraction add) into the
// result register. A byte that yields no result may pass while a result
// waits to be taken. Characters beyond FIELD_CHARS are dropped. No
// clearing pass after reset.
// ----------------------------------------------------------------------------
`include "ascii_xy_packet_parser_unit_assert.svh"

module ascii_xy_packet_parser_unit #(
	parameter int FIELD_CHARS   = xyp_pkg::FIELD_CHARS_DEF,
	parameter int FRACTION_BITS = xyp_pkg::FRACTION_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  xyp_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output xyp_pkg::result_t result
);
	import xyp_pkg::*;

	// input register
	logic  valid_s1;
	item_t item_s1;

	// result register
	logic    result_valid_q;
	result_t result_q;

	logic     accept;
	logic     advance;
	logic     step;
	logic     has_result;
	frm_t     frm;
	fld_ctl_t x_ctl;
	fld_ctl_t y_ctl;
	fld_t     x_st;
	fld_t     y_st;
	result_t  result_nx;

	// assertion helpers
	logic     any_capture;
	logic     timeout_adv;
	logic     result_zero;
	logic     load_result;

	// --- frame tracking ---
	xyp_frame u_frame (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.ch     (item_s1.rx_byte),
		.frm    (frm)
	);

	// --- field units; a letter in frame starts its own field and stops the other ---
	always_comb begin
		x_ctl.take    = step;
		x_ctl.start   = frm.in_frame && (item_s1.rx_byte == CHAR_X);
		x_ctl.stop    = frm.in_frame && (item_s1.rx_byte == CHAR_Y);
		x_ctl.trailer = frm.trailer;
		y_ctl.take    = step;
		y_ctl.start   = x_ctl.stop;
		y_ctl.stop    = x_ctl.start;
		y_ctl.trailer = frm.trailer;
	end

	xyp_field #(
		.FIELD_CHARS   (FIELD_CHARS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_field_x (
		.clk    (clk),
		.arst_n (arst_n),
		.ch     (item_s1.rx_byte),
		.ctl    (x_ctl),
		.st     (x_st)
	);

	xyp_field #(
		.FIELD_CHARS   (FIELD_CHARS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_field_y (
		.clk    (clk),
		.arst_n (arst_n),
		.ch     (item_s1.rx_byte),
		.ctl    (y_ctl),
		.st     (y_st)
	);

	// --- result formation ---
	// Field values are read before this byte updates them: the trailer
	// reports what was captured up to the first 'E'.
	always_comb begin
		if (item_s1.op == OP_TIMEOUT) begin
			has_result         = 1'b1;
			result_nx.x_update = 1'b1;
			result_nx.x_value  = '0;
			result_nx.y_update = 1'b1;
			result_nx.y_value  = '0;
		end else begin
			has_result         = frm.trailer && (x_st.has_chars || y_st.has_chars);
			result_nx.x_update = x_st.has_chars;
			result_nx.x_value  = x_st.has_chars ? x_st.value : '0;
			result_nx.y_update = y_st.has_chars;
			result_nx.y_value  = y_st.has_chars ? y_st.value : '0;
		end
	end

	// --- handshake ---
	// The held item moves on when the result register is free or draining,
	// or right away when it yields no result.
	assign advance    = valid_s1 && (!has_result || !result_valid_q || !result_stall);
	assign step       = advance && (item_s1.op == OP_BYTE);
	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance && has_result) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			result_q <= result_nx;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// --- assertions ---
	assign any_capture = x_st.capturing || y_st.capturing;
	assign timeout_adv = advance && (item_s1.op == OP_TIMEOUT);
	assign result_zero = result_q.x_update && result_q.y_update
		&& (result_q.x_value == '0) && (result_q.y_value == '0);
	assign load_result = advance && has_result;

	`XYP_ASSERT(a_single_capture, !(x_st.capturing && y_st.capturing), "both fields capturing")
	`XYP_ASSERT(a_trailer_closes, step && frm.trailer |=> !any_capture, "capture open after trailer")
	`XYP_ASSERT(a_timeout_zero, timeout_adv |=> result_valid_q && result_zero, "timeout result not zero")
	`XYP_ASSERT(a_no_overwrite, result_valid_q && result_stall |-> !load_result, "result overwritten")
	`XYP_ASSERT_ALWAYS(a_reset_empty, !arst_n |=> !result_valid_q && !valid_s1, "not empty in reset")

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb - ASCII X/Y packet parser testbench
// Sends byte and receive-timeout transfers into the parser and keeps its own
// running parse of the frame stream. Each accepted input that closes a frame
// or times out queues the report it should cause. Every result transfer is
// checked field by field against the oldest queued report. Directed frames
// cover framing, sign, points, full fields and saturation. Then come a
// full-rate burst, a long receiver hold-off and randomly built frames with
// noise; all but the full-rate burst run under random idling on both sides.
// ----------------------------------------------------------------------------
module tb;
	import xyp_pkg::*;

	localparam int FIELD_LEN     = FIELD_CHARS_DEF;
	localparam int FRAC_BITS     = FRACTION_BITS_DEF;
	localparam int ITEM_TARGET   = 1300;
	// Watchdog bound on the whole run.
	localparam int CYCLE_LIMIT   = 400000;
	localparam int DRAIN_CYCLES  = 20;
	localparam int HOLD_LEN      = 150;
	localparam int ERR_PRINT_MAX = 30;
	localparam int IDLE_PCT      = 35;
	localparam int FX            = 0;
	localparam int FY            = 1;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_stall;
	item_t   item;
	logic    result_valid;
	logic    result_stall;
	result_t result;

	ascii_xy_packet_parser_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// ------------------------------------------------------------------
	// Shared run controls and counters
	// ------------------------------------------------------------------
	bit no_idle     = 1'b0;  // both sides run flat out while set
	int hold_cycles = 0;     // receiver stalls this many cycles, counted down
	int errors      = 0;
	int cycle_count = 0;
	int items_sent  = 0;
	int timeouts_sent = 0;
	int frames_sent = 0;
	int reports_checked = 0;

	// ------------------------------------------------------------------
	// Shadow parse state: one entry per field, X then Y
	// ------------------------------------------------------------------
	frame_state_t    frame_pos;
	logic            capture    [2];
	int unsigned     char_count [2];
	logic            minus      [2];
	logic            past_point [2];
	int unsigned     frac_place [2];
	longint unsigned magnitude  [2];

	// Reports owed by the parser, oldest first
	result_t pending_reports [$];

	// ------------------------------------------------------------------
	// Clock, watchdog
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("watchdog expired after %0d cycles, %0d reports outstanding",
				cycle_count, pending_reports.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic report_mismatch(string msg);
		errors++;
		if (errors <= ERR_PRINT_MAX)
			$display("[%0t] MISMATCH %s", $time, msg);
	endtask

	// ------------------------------------------------------------------
	// Parse prediction
	// ------------------------------------------------------------------
	function automatic void clear_field(int f);
		char_count[f] = 0;
		minus[f]      = 1'b0;
		past_point[f] = 1'b0;
		frac_place[f] = 0;
		magnitude[f]  = 0;
	endfunction

	function automatic void reset_shadow();
		frame_pos = FP_IDLE;
		capture[FX] = 1'b0;
		capture[FY] = 1'b0;
		clear_field(FX);
		clear_field(FY);
	endfunction

	// One captured character. Anything that is not a digit, a leading minus
	// or a point still uses up a slot in the field.
	function automatic void take_char(int f, logic [7:0] ch);
		longint unsigned m;
		longint unsigned digit;
		longint unsigned scale;
		m = magnitude[f];
		if (char_count[f] >= FIELD_LEN)
			return;
		if (char_count[f] == 0 && ch == CHAR_MINUS) begin
			minus[f] = 1'b1;
		end else if (ch >= CHAR_0 && ch <= CHAR_9) begin
			digit = longint'(ch - CHAR_0);
			if (!past_point[f]) begin
				m = m * 10 + (digit << FRAC_BITS);
			end else begin
				if (frac_place[f] < 15)
					frac_place[f]++;
				scale = 1;
				repeat (frac_place[f]) scale = scale * 10;
				// rounded digit * 2^FRAC_BITS / 10^place
				m = m + ((digit << (FRAC_BITS + 1)) + scale) / (2 * scale);
			end
			if (m > longint'(MAG_MAX))
				m = longint'(MAG_MAX);
			magnitude[f] = m;
		end
		if (ch == CHAR_POINT) begin
			past_point[f] = 1'b1;
			frac_place[f] = 0;
		end
		char_count[f]++;
	endfunction

	function automatic logic [VAL_W-1:0] field_value(int f);
		logic [VAL_W-1:0] v;
		v = magnitude[f][VAL_W-1:0];
		return minus[f] ? -v : v;
	endfunction

	function automatic void predict_report(item_t it);
		result_t    rep;
		logic [7:0] ch;
		logic       trailer_done;
		ch = it.rx_byte;
		trailer_done = 1'b0;
		rep = '0;
		// Timeout: zeros on both axes, parse state untouched
		if (it.op == OP_TIMEOUT) begin
			rep.x_update = 1'b1;
			rep.y_update = 1'b1;
			pending_reports.push_back(rep);
			return;
		end
		case (frame_pos)
			FP_IDLE:     frame_pos = (ch == CHAR_A) ? FP_ONE_A : FP_IDLE;
			// a wrong second header byte is not retried as a first 'A'
			FP_ONE_A:    frame_pos = (ch == CHAR_A) ? FP_IN_FRAME : FP_IDLE;
			FP_IN_FRAME: frame_pos = (ch == CHAR_E) ? FP_ONE_E : FP_IN_FRAME;
			FP_ONE_E: begin
				// a lone 'E' falls back into the frame; this byte is a frame byte
				if (ch == CHAR_E)
					trailer_done = 1'b1;
				else
					frame_pos = FP_IN_FRAME;
			end
			default:     frame_pos = FP_IDLE;
		endcase
		if (trailer_done) begin
			frame_pos = FP_IDLE;
			capture[FX] = 1'b0;
			capture[FY] = 1'b0;
			// stale fields from earlier frames are reported again
			if (char_count[FX] != 0 || char_count[FY] != 0) begin
				if (char_count[FX] != 0) begin
					rep.x_update = 1'b1;
					rep.x_value  = field_value(FX);
				end
				if (char_count[FY] != 0) begin
					rep.y_update = 1'b1;
					rep.y_value  = field_value(FY);
				end
				pending_reports.push_back(rep);
			end
		end
		// the letter that ends a capture still counts toward the old field
		for (int f = 0; f < 2; f++)
			if (capture[f])
				take_char(f, ch);
		if (frame_pos == FP_IN_FRAME && ch == CHAR_X) begin
			capture[FX] = 1'b1;
			capture[FY] = 1'b0;
			clear_field(FX);
		end
		if (frame_pos == FP_IN_FRAME && ch == CHAR_Y) begin
			capture[FX] = 1'b0;
			capture[FY] = 1'b1;
			clear_field(FY);
		end
	endfunction

	// ------------------------------------------------------------------
	// Result side: stall generator and checker
	// ------------------------------------------------------------------
	initial begin : receiver
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				result_stall <= 1'b1;
				hold_cycles--;
			end else if (no_idle) begin
				result_stall <= 1'b0;
			end else begin
				result_stall <= ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && result_valid === 1'b1 && result_stall === 1'b0) begin
			if (pending_reports.size() == 0) begin
				report_mismatch($sformatf("unexpected result x=%0d/%h y=%0d/%h",
					result.x_update, result.x_value, result.y_update, result.y_value));
			end else begin
				want = pending_reports.pop_front();
				reports_checked++;
				if (result.x_update !== want.x_update)
					report_mismatch($sformatf("x_update got %b want %b",
						result.x_update, want.x_update));
				if (result.x_value !== want.x_value)
					report_mismatch($sformatf("x_value got %h want %h",
						result.x_value, want.x_value));
				if (result.y_update !== want.y_update)
					report_mismatch($sformatf("y_update got %b want %b",
						result.y_update, want.y_update));
				if (result.y_value !== want.y_value)
					report_mismatch($sformatf("y_value got %h want %h",
						result.y_value, want.y_value));
			end
		end
	end

	// ------------------------------------------------------------------
	// Input side. All send tasks start and end at a falling edge.
	// ------------------------------------------------------------------
	task automatic send_item(item_t it);
		// random gaps before the transfer; valid only drops while idling
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		do @(posedge clk); while (item_stall !== 1'b0);
		predict_report(it);
		items_sent++;
		if (it.op == OP_TIMEOUT)
			timeouts_sent++;
		@(negedge clk);
	endtask

	task automatic send_byte(logic [7:0] ch);
		item_t it;
		it.op      = OP_BYTE;
		it.rx_byte = ch;
		send_item(it);
	endtask

	task automatic send_timeout();
		item_t it;
		it.op      = OP_TIMEOUT;
		it.rx_byte = 8'($urandom_range(255));  // ignored by the parser
		send_item(it);
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic send_digit();
		send_byte(CHAR_0 + 8'($urandom_range(9)));
	endtask

	// Sender goes quiet until the parser has delivered everything it owes.
	task automatic drain_reports();
		item_valid <= 1'b0;
		do @(negedge clk); while (pending_reports.size() != 0);
	endtask

	// Mostly well-formed frame with random fields; a few stray bytes,
	// broken trailers, second points and overlong fields mixed in.
	task automatic send_random_frame();
		int n_fields;
		int n_int;
		n_fields = $urandom_range(0, 3);
		if ($urandom_range(9) == 0)
			send_byte(8'($urandom_range(255)));
		send_byte(CHAR_A);
		send_byte(CHAR_A);
		repeat (n_fields) begin
			send_byte($urandom_range(1) ? CHAR_X : CHAR_Y);
			if ($urandom_range(99) < 40)
				send_byte(CHAR_MINUS);
			// long integer parts overflow the field and saturate
			n_int = ($urandom_range(9) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 3);
			repeat (n_int) send_digit();
			if ($urandom_range(99) < 70) begin
				send_byte(CHAR_POINT);
				repeat ($urandom_range(0, 6)) send_digit();
				if ($urandom_range(9) == 0) begin
					send_byte(CHAR_POINT);
					repeat ($urandom_range(0, 3)) send_digit();
				end
			end
			if ($urandom_range(9) == 0)
				send_byte(8'($urandom_range(255)));
			if ($urandom_range(11) == 0) begin
				send_byte(CHAR_E);
				send_digit();
			end
			if ($urandom_range(19) == 0)
				send_timeout();
		end
		send_byte(CHAR_E);
		if ($urandom_range(19) != 0)
			send_byte(CHAR_E);
		frames_sent++;
	endtask

	task automatic send_noise();
		repeat ($urandom_range(1, 8)) begin
			if ($urandom_range(9) == 0)
				send_timeout();
			else
				send_byte(8'($urandom_range(255)));
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Extreme byte codes and a letter outside any frame, a broken header,
	// an empty frame that must stay silent, then a timeout.
	task automatic test_framing();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_text("XABAAEE");
		send_timeout();
	endtask

	// Leading and late minus, second point, a lone trailer 'E' inside the
	// field, a letter ending capture, then a frame that repeats stale fields.
	task automatic test_field_syntax();
		send_text("AAX-9-.5.5E3Y-EE");
		send_text("AAEE");
		frames_sent += 2;
	endtask

	// Ten integer digits saturate the magnitude; further digits are dropped.
	task automatic test_field_limits();
		send_text("AAY1234567890123EE");
		frames_sent++;
	endtask

	task automatic test_full_rate();
		no_idle = 1'b1;
		repeat (12) send_random_frame();
		no_idle = 1'b0;
	endtask

	// Receiver stops for a long stretch while timeouts and frames keep
	// coming, so the result register fills and the input stalls.
	task automatic test_backpressure();
		hold_cycles = HOLD_LEN;
		repeat (6) begin
			send_timeout();
			send_random_frame();
		end
		drain_reports();
	endtask

	task automatic test_random_frames();
		int pick;
		while (items_sent < ITEM_TARGET) begin
			pick = $urandom_range(99);
			if (pick < 75)
				send_random_frame();
			else if (pick < 90)
				send_noise();
			else if (pick < 96)
				send_timeout();
			else
				drain_reports();
		end
	endtask

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	initial begin : sequencer
		arst_n     = 1'b0;
		item_valid = 1'b0;
		item       = '0;
		reset_shadow();
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_framing();
		test_field_syntax();
		test_field_limits();
		test_full_rate();
		test_backpressure();
		test_random_frames();

		// wind down: no more transfers, collect what is owed, then watch
		// a little longer for stray results
		item_valid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d transfers (%0d timeouts) in about %0d frames,",
			items_sent, timeouts_sent, frames_sent);
		$display("checked %0d reports.", reports_checked);
		$display("Included framing edge cases, field limits, a full-rate burst");
		$display("and a %0d-cycle hold-off.", HOLD_LEN);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

[files.f]
+incdir+design
design/xyp_pkg.sv
design/xyp_frame.sv
design/xyp_field.sv
design/ascii_xy_packet_parser_unit.sv
tb/tb.sv
